// File: hw/rtl/log_ring_record_allocator_defines.svh
// Assertion macros for the log ring record allocator checker.
// No dependencies; included by files that assert.
`ifndef LOG_RING_RECORD_ALLOCATOR_DEFINES_SVH
`define LOG_RING_RECORD_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define LRRA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrra assertion failed");

// next-cycle implication, off during reset
`define LRRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrra assertion failed");

// next-cycle implication, always on
`define LRRA_ASSERT_NEXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lrra assertion failed");

`endif

// File: hw/rtl/lrra_pkg.sv
// Package for the log ring record allocator: sizes, codes and widths.
// No dependencies.
package lrra_pkg;
    localparam int AREA_BYTES       = 16384;
    localparam int MIN_RECORD_BYTES = 28;
    localparam int MAX_RECORD_BYTES = 1024;
    localparam int STORE_DEPTH      = AREA_BYTES / 4;
    localparam int IDX_W            = $clog2(STORE_DEPTH);
    localparam int WALK_LIMIT       = 2 * STORE_DEPTH + 4;
    localparam int STEP_W           = $clog2(WALK_LIMIT + 1);

    typedef enum logic [1:0] {
        K_ALLOC  = 2'd0,
        K_COMMIT = 2'd1,
        K_PAUSE  = 2'd2,
        K_RESUME = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_BAD_LEN = 2'd2,
        ST_BLOCKED = 2'd3
    } t_status;

    localparam logic [1:0] CFG_MANAGER_EN   = 2'd0;
    localparam logic [1:0] CFG_RECORDING_EN = 2'd1;
    localparam logic [1:0] CFG_AREA_BYTES   = 2'd2;
endpackage

// File: hw/rtl/log_ring_record_allocator.sv
// Commit, pause, resume, refused and bad-length allocations go to S_DONE, which
// registers o_valid; an allocation runs S_WALK/S_DATA per evicted record, then S_PREV,
// S_PREVD if the previous size is read, S_WRITE, S_DONE; a blocked one jumps to S_DONE.
// Throughput: one transaction at a time; the next is accepted the cycle after the result
// is staged, which waits only while an older result is held by i_stall.
// Reset (i_rst_n low, synchronous) resets pointers, counters and config; memories are not.
module log_ring_record_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_kind,
    input  logic [15:0]                i_length,
    input  logic [15:0]                i_level,
    input  logic [13:0]                i_commit_position,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_status,
    output logic [13:0]                o_position,
    output logic [31:0]                o_record_number,
    output logic [14:0]                o_previous_size,
    output logic [13:0]                o_oldest_position,
    output logic signed [15:0]         o_pause_depth_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [14:0]                i_cfg_data
);
    import lrra_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_DATA, S_PREV, S_PREVD, S_WRITE, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic        r_men, n_men, r_ren, n_ren;
    logic [14:0] r_area, n_area;
    logic [14:0] r_oldest, n_oldest, r_used, n_used, r_newest, n_newest, r_free, n_free;
    logic [31:0] r_seq, n_seq;
    logic [15:0] r_pause, n_pause;
    logic [15:0] r_len4, n_len4, r_apos, n_apos, r_bot, n_bot, r_first, n_first;
    logic [15:0] r_next, n_next;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic [14:0] r_prev, n_prev;
    logic [1:0]  r_res_status, n_res_status;
    logic [13:0] r_res_pos, n_res_pos;
    logic [31:0] r_res_num, n_res_num;
    logic [14:0] r_res_prev, n_res_prev;
    logic [15:0] r_res_depth, n_res_depth;
    logic        r_ov, n_ov;
    logic [1:0]  r_o_status, n_o_status;
    logic [13:0] r_o_pos, n_o_pos, r_o_old, n_o_old;
    logic [31:0] r_o_num, n_o_num;
    logic [14:0] r_o_prev, n_o_prev;
    logic [15:0] r_o_depth, n_o_depth;

    // size and pending stores
    logic [14:0] m_size [STORE_DEPTH];
    logic        m_pend [STORE_DEPTH];
    logic             rd_en, we_size, we_pend, wpend;
    logic [15:0]      rd_addr, wr_addr;
    logic [14:0]      wsize;
    logic [14:0]      r_rd_size;
    logic             r_rd_pend, r_rd_in;
    logic [14:0]      eff_size;
    logic             eff_pend;

    always_ff @(posedge i_clk) begin
        if (we_size) begin
            m_size[wr_addr[IDX_W+1:2]] <= wsize;
        end
        if (we_pend) begin
            m_pend[wr_addr[IDX_W+1:2]] <= wpend;
        end
        if (rd_en) begin
            r_rd_size <= m_size[rd_addr[IDX_W+1:2]];
            r_rd_pend <= m_pend[rd_addr[IDX_W+1:2]];
            r_rd_in   <= (rd_addr[15:IDX_W+2] == '0);
        end
    end

    assign eff_size = r_rd_in ? r_rd_size : 15'd0;
    assign eff_pend = r_rd_in & r_rd_pend;

    logic [15:0] area_eff, len_in, len4_in, free_end;
    logic [15:0] win_a_end, win_n_end;
    logic [16:0] nf;
    logic        refused, bad_len, walk_go, in_win;
    logic        accept;

    always_comb begin
        area_eff = {1'b0, r_area & 15'h7FFC};
        if (area_eff > 16'(AREA_BYTES)) begin
            area_eff = 16'(AREA_BYTES);
        end
    end

    assign accept    = i_valid && !o_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign len_in    = i_length;
    assign len4_in   = (len_in + 16'd3) & 16'hFFFC;
    assign free_end  = {1'b0, r_free} + len4_in;
    assign refused   = !r_men || !r_ren || (!r_pause[15] && r_pause != 16'd0);
    assign bad_len   = (len_in < 16'(MIN_RECORD_BYTES)) || (len_in > 16'(MAX_RECORD_BYTES))
                       || (len_in > area_eff);
    assign win_a_end = r_apos + r_len4;
    assign win_n_end = r_next + r_len4;
    assign in_win    = (r_first >= r_apos && r_first < win_a_end) ||
                       (r_first >= r_next && r_first < win_n_end);
    assign walk_go   = in_win && (r_first < r_bot);
    assign nf        = {1'b0, r_first} + {2'b0, eff_size};

    always_comb begin
        n_state = r_state;
        n_men = r_men; n_ren = r_ren; n_area = r_area;
        n_oldest = r_oldest; n_used = r_used; n_newest = r_newest; n_free = r_free;
        n_seq = r_seq; n_pause = r_pause;
        n_len4 = r_len4; n_apos = r_apos; n_bot = r_bot; n_first = r_first;
        n_next = r_next; n_steps = r_steps; n_prev = r_prev;
        n_res_status = r_res_status; n_res_pos = r_res_pos; n_res_num = r_res_num;
        n_res_prev = r_res_prev; n_res_depth = r_res_depth;
        n_ov = r_ov && i_stall;
        n_o_status = r_o_status; n_o_pos = r_o_pos; n_o_old = r_o_old;
        n_o_num = r_o_num; n_o_prev = r_o_prev; n_o_depth = r_o_depth;
        rd_en = 1'b0; rd_addr = r_first;
        we_size = 1'b0; we_pend = 1'b0; wr_addr = r_apos; wsize = r_len4[14:0];
        wpend = 1'b1;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MANAGER_EN:   n_men  = i_cfg_data[0];
                CFG_RECORDING_EN: n_ren  = i_cfg_data[0];
                CFG_AREA_BYTES:   n_area = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_status = ST_OK;
                    n_res_pos    = '0;
                    n_res_num    = '0;
                    n_res_prev   = '0;
                    n_res_depth  = r_pause;
                    n_state      = S_DONE;
                    case (t_kind'(i_kind))
                        K_ALLOC: begin
                            if (refused) begin
                                n_res_status = ST_REFUSED;
                            end else if (bad_len) begin
                                n_res_status = ST_BAD_LEN;
                            end else begin
                                n_len4  = len4_in;
                                n_apos  = (free_end <= area_eff) ? {1'b0, r_free} : 16'd0;
                                n_bot   = {1'b0, r_used};
                                n_first = {1'b0, r_oldest};
                                n_next  = {1'b0, r_free};
                                n_steps = '0;
                                n_state = S_WALK;
                            end
                        end
                        K_COMMIT: begin
                            we_pend = 1'b1;
                            wpend   = 1'b0;
                            wr_addr = {2'b0, i_commit_position & 14'h3FFC};
                        end
                        K_PAUSE: begin
                            if (!r_men) begin
                                n_res_status = ST_REFUSED;
                                n_res_depth  = 16'hFFFF;
                            end else begin
                                n_pause = r_pause + 16'd1;
                            end
                        end
                        K_RESUME: begin
                            if (!r_men) begin
                                n_res_status = ST_REFUSED;
                                n_res_depth  = 16'hFFFF;
                            end else begin
                                n_pause     = r_pause - 16'd1;
                                n_res_depth = r_pause - 16'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (!walk_go || r_steps >= STEP_W'(WALK_LIMIT)) begin
                    n_state = S_PREV;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_first;
                    n_steps = r_steps + 1'b1;
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (eff_pend) begin
                    n_res_status = ST_BLOCKED;
                    n_state      = S_DONE;
                end else if (nf >= {1'b0, r_bot}) begin
                    n_first = '0;
                    if (r_apos == 16'd0 && nf == {1'b0, r_next}) begin
                        n_bot   = '0;
                        n_next  = '0;
                        n_state = S_PREV;
                    end else if (r_apos != r_next) begin
                        n_bot   = r_next;
                        n_state = S_WALK;
                    end else begin
                        n_bot   = win_a_end;
                        n_state = S_PREV;
                    end
                end else begin
                    n_first = nf[15:0];
                    n_state = S_WALK;
                end
            end
            S_PREV: begin
                if (r_first != r_apos) begin
                    rd_en   = 1'b1;
                    rd_addr = {1'b0, r_newest};
                    n_state = S_PREVD;
                end else begin
                    n_prev  = '0;
                    n_state = S_WRITE;
                end
            end
            S_PREVD: begin
                n_prev  = eff_size;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (r_apos[15:IDX_W+2] == '0) begin
                    we_size = 1'b1;
                    we_pend = 1'b1;
                end
                n_used       = (r_bot < win_a_end) ? win_a_end[14:0] : r_bot[14:0];
                n_oldest     = r_first[14:0];
                n_newest     = r_apos[14:0];
                n_free       = win_a_end[14:0];
                n_res_status = ST_OK;
                n_res_pos    = r_apos[13:0];
                n_res_num    = r_seq;
                n_res_prev   = r_prev;
                n_seq        = r_seq + 32'd1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || !i_stall) begin
                    n_ov       = 1'b1;
                    n_o_status = r_res_status;
                    n_o_pos    = r_res_pos;
                    n_o_num    = r_res_num;
                    n_o_prev   = r_res_prev;
                    n_o_old    = r_oldest[13:0];
                    n_o_depth  = r_res_depth;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_men    <= 1'b0;
            r_ren    <= 1'b0;
            r_area   <= 15'(AREA_BYTES);
            r_oldest <= '0;
            r_used   <= '0;
            r_newest <= '0;
            r_free   <= '0;
            r_seq    <= '0;
            r_pause  <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_men    <= n_men;
            r_ren    <= n_ren;
            r_area   <= n_area;
            r_oldest <= n_oldest;
            r_used   <= n_used;
            r_newest <= n_newest;
            r_free   <= n_free;
            r_seq    <= n_seq;
            r_pause  <= n_pause;
            r_ov     <= n_ov;
        end
        r_len4       <= n_len4;
        r_apos       <= n_apos;
        r_bot        <= n_bot;
        r_first      <= n_first;
        r_next       <= n_next;
        r_steps      <= n_steps;
        r_prev       <= n_prev;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_res_num    <= n_res_num;
        r_res_prev   <= n_res_prev;
        r_res_depth  <= n_res_depth;
        r_o_status   <= n_o_status;
        r_o_pos      <= n_o_pos;
        r_o_old      <= n_o_old;
        r_o_num      <= n_o_num;
        r_o_prev     <= n_o_prev;
        r_o_depth    <= n_o_depth;
    end

    assign o_valid           = r_ov;
    assign o_status          = r_o_status;
    assign o_position        = r_o_pos;
    assign o_record_number   = r_o_num;
    assign o_previous_size   = r_o_prev;
    assign o_oldest_position = r_o_old;
    assign o_pause_depth_out = $signed(r_o_depth);

    // level travels with the record body, held outside this block
    logic unused_level;
    assign unused_level = ^i_level;
endmodule

// File: hw/rtl/lrra_checker.sv
// Port-level checker for the log ring record allocator, bound to the top level.
// Depends on lrra_pkg and log_ring_record_allocator_defines.svh.
`include "log_ring_record_allocator_defines.svh"
module lrra_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [1:0]          o_status,
    input logic [13:0]         o_position,
    input logic [31:0]         o_record_number,
    input logic [14:0]         o_previous_size
);
    import lrra_pkg::*;

    `LRRA_ASSERT_NEXT_ALL(a_reset_clears, i_clk, !i_rst_n, !o_valid)
    `LRRA_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `LRRA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `LRRA_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK,
        o_position == 14'd0 && o_record_number == 32'd0 && o_previous_size == 15'd0)
endmodule

bind log_ring_record_allocator lrra_checker u_lrra_checker (.*);

// File: tb/tb_log_ring_record_allocator.sv
// Self-checking bench for log_ring_record_allocator: drives alloc, commit,
// pause and resume transactions and checks every result against a local model.
// Depends on lrra_pkg and the log_ring_record_allocator RTL.
`timescale 1ns / 100ps

module tb_log_ring_record_allocator;
    import lrra_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] length;
        logic [15:0] level;
        logic [13:0] cpos;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [13:0]        position;
        logic [31:0]        recno;
        logic [14:0]        prior_size;
        logic [13:0]        oldest;
        logic signed [15:0] depth;
    } t_resp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_kind = '0;
    logic [15:0] i_length = '0;
    logic [15:0] i_level = '0;
    logic [13:0] i_commit_position = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_status;
    logic [13:0] o_position;
    logic [31:0] o_record_number;
    logic [14:0] o_previous_size;
    logic [13:0] o_oldest_position;
    logic signed [15:0] o_pause_depth_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [14:0] i_cfg_data = '0;

    always #4 i_clk = ~i_clk;

    log_ring_record_allocator u_top (.*);

    // model state
    logic        mgr_en, rec_en;
    logic [14:0] area_reg;
    int unsigned oldest_off, used_end, newest_off, free_off;
    logic [31:0] seq_cnt;
    logic [15:0] pause_cnt;
    logic [14:0] size_mem [STORE_DEPTH];
    logic        pend_mem [STORE_DEPTH];

    t_req  pending_reqs[$];
    t_resp expected_resps[$];
    int    err_cnt = 0;
    int    quiet_cycles = 0;
    bit    no_idle = 0;
    bit    sender_hold = 0;
    int    rx_hold = 0;
    int    tx_gap = 0, rx_gap = 0;

    function automatic int unsigned size_of(int unsigned p);
        return ((p >> 2) < STORE_DEPTH) ? 32'(size_mem[p >> 2]) : 0;
    endfunction

    function automatic bit pend_of(int unsigned p);
        return ((p >> 2) < STORE_DEPTH) ? pend_mem[p >> 2] : 1'b0;
    endfunction

    function automatic t_resp predict_alloc_result(t_req r);
        t_resp o;
        int unsigned area, len, apos, bot, first, nxt, prv, steps;
        o = '0;
        if (r.kind == K_ALLOC) begin
            area = 32'(area_reg & 15'h7ffc);
            if (area > AREA_BYTES) area = AREA_BYTES;
            len = 32'(r.length);
            if (!mgr_en || !rec_en || (!pause_cnt[15] && pause_cnt != 0)) begin
                o.status = ST_REFUSED;
            end else if (len < MIN_RECORD_BYTES || len > MAX_RECORD_BYTES || len > area) begin
                o.status = ST_BAD_LEN;
            end else begin
                len = (len + 3) & ~32'd3;
                apos = (free_off + len <= area) ? free_off : 0;
                bot = used_end;
                first = oldest_off;
                nxt = free_off;
                steps = 0;
                o.status = ST_OK;
                while (((first >= apos && first < apos + len) ||
                        (first >= nxt && first < nxt + len)) && first < bot) begin
                    if (steps >= WALK_LIMIT) break;
                    steps++;
                    if (pend_of(first)) begin
                        o.status = ST_BLOCKED;
                        break;
                    end
                    first += size_of(first);
                    if (first >= bot) begin
                        if (apos == 0 && first == nxt) begin
                            bot = 0; first = 0; nxt = 0;
                            break;
                        end
                        first = 0;
                        if (apos != nxt) begin
                            bot = nxt;
                            continue;
                        end
                        bot = apos + len;
                        break;
                    end
                end
                if (o.status == ST_OK) begin
                    prv = (first != apos) ? size_of(newest_off) : 0;
                    if ((apos >> 2) < STORE_DEPTH) begin
                        size_mem[apos >> 2] = len[14:0];
                        pend_mem[apos >> 2] = 1'b1;
                    end
                    if (bot < apos + len) bot = apos + len;
                    used_end = bot;
                    oldest_off = first;
                    newest_off = apos;
                    free_off = apos + len;
                    o.position = apos[13:0];
                    o.recno = seq_cnt;
                    o.prior_size = prv[14:0];
                    seq_cnt++;
                end
            end
            o.depth = pause_cnt;
        end else if (r.kind == K_COMMIT) begin
            pend_mem[r.cpos[13:2]] = 1'b0;
            o.depth = pause_cnt;
        end else if (!mgr_en) begin
            o.status = ST_REFUSED;
            o.depth = -16'sd1;
        end else if (r.kind == K_PAUSE) begin
            o.depth = pause_cnt;
            pause_cnt++;
        end else begin
            pause_cnt--;
            o.depth = pause_cnt;
        end
        o.oldest = oldest_off[13:0];
        return o;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_resps.push_back(predict_alloc_result(
                    {i_kind, i_length, i_level, i_commit_position}));
            end
            if (!i_valid || !o_stall) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !sender_hold) begin
                    t_req r;
                    r = pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    i_kind <= r.kind;
                    i_length <= r.length;
                    i_level <= r.level;
                    i_commit_position <= r.cpos;
                    if (!no_idle && $urandom_range(0, 9) == 0)
                        tx_gap <= $urandom_range(1, 16);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_resps.size() == 0) begin
                    $error("unexpected result");
                    err_cnt++;
                end else begin
                    t_resp e;
                    e = expected_resps.pop_front();
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status); err_cnt++;
                    end
                    if (o_position !== e.position) begin
                        $error("position exp %0d got %0d", e.position, o_position); err_cnt++;
                    end
                    if (o_record_number !== e.recno) begin
                        $error("record_number exp %0d got %0d", e.recno, o_record_number);
                        err_cnt++;
                    end
                    if (o_previous_size !== e.prior_size) begin
                        $error("previous_size exp %0d got %0d", e.prior_size, o_previous_size);
                        err_cnt++;
                    end
                    if (o_oldest_position !== e.oldest) begin
                        $error("oldest_position exp %0d got %0d", e.oldest, o_oldest_position);
                        err_cnt++;
                    end
                    if (o_pause_depth_out !== e.depth) begin
                        $error("pause_depth_out exp %0d got %0d", e.depth, o_pause_depth_out);
                        err_cnt++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                i_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (!no_idle && $urandom_range(0, 9) == 0) rx_gap <= $urandom_range(1, 16);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || rx_hold > 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_valid || expected_resps.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MANAGER_EN:   mgr_en = val[0];
            CFG_RECORDING_EN: rec_en = val[0];
            CFG_AREA_BYTES:   area_reg = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_req mk(logic [1:0] k, logic [15:0] l, logic [13:0] c);
        t_req r;
        r.kind = k; r.length = l; r.level = 16'($urandom); r.cpos = c;
        return r;
    endfunction

    // mixed traffic: allocations, random commits, pause pairs and raw transactions
    task automatic queue_traffic(int n, int maxlen);
        int unsigned live[$];
        int unsigned pos;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 19);
            if (k < 10) begin
                pending_reqs.push_back(mk(K_ALLOC,
                    16'($urandom_range(MIN_RECORD_BYTES, maxlen)), 14'd0));
            end else if (k < 17) begin
                pos = $urandom_range(0, 4095) * 4;
                pending_reqs.push_back(mk(K_COMMIT, 16'd0, 14'(pos + $urandom_range(0, 3))));
            end else if (k == 17) begin
                pending_reqs.push_back(mk(K_PAUSE, 16'($urandom), 14'($urandom)));
                pending_reqs.push_back(mk(K_ALLOC, 16'($urandom), 14'($urandom)));
                pending_reqs.push_back(mk(K_RESUME, 16'($urandom), 14'($urandom)));
            end else begin
                pending_reqs.push_back(mk(2'($urandom), 16'($urandom), 14'($urandom)));
            end
        end
    endtask

    // commit every entry the model still holds as pending; only call when drained
    task automatic queue_commit_all();
        for (int i = 0; i < STORE_DEPTH; i++)
            if (pend_mem[i] === 1'b1)
                pending_reqs.push_back(mk(K_COMMIT, 16'd0, 14'(i * 4)));
    endtask

    initial begin
        mgr_en = 0; rec_en = 0; area_reg = 15'd16384;
        oldest_off = 0; used_end = 0; newest_off = 0; free_off = 0;
        seq_cnt = 0; pause_cnt = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // refused while disabled; the commit still succeeds
        pending_reqs.push_back(mk(K_ALLOC, 16'd100, 14'd0));
        pending_reqs.push_back(mk(K_PAUSE, 16'd0, 14'd0));
        pending_reqs.push_back(mk(K_RESUME, 16'hffff, 14'h3fff));
        pending_reqs.push_back(mk(K_COMMIT, 16'hffff, 14'h3fff));
        wait_drained();
        write_reg(CFG_MANAGER_EN, 15'd1);
        pending_reqs.push_back(mk(K_ALLOC, 16'd100, 14'd0));
        wait_drained();
        write_reg(CFG_RECORDING_EN, 15'd1);
        write_reg(CFG_AREA_BYTES, 15'd64);
        pending_reqs.push_back(mk(K_ALLOC, 16'd27, 14'd0));
        pending_reqs.push_back(mk(K_ALLOC, 16'd65, 14'd0));
        pending_reqs.push_back(mk(K_ALLOC, 16'hffff, 14'd0));
        pending_reqs.push_back(mk(K_ALLOC, 16'd28, 14'd0));
        pending_reqs.push_back(mk(K_ALLOC, 16'd29, 14'd0));
        pending_reqs.push_back(mk(K_ALLOC, 16'd28, 14'd0));
        pending_reqs.push_back(mk(K_COMMIT, 16'd0, 14'd1));
        pending_reqs.push_back(mk(K_COMMIT, 16'd0, 14'd32));
        pending_reqs.push_back(mk(K_ALLOC, 16'd64, 14'd0));
        pending_reqs.push_back(mk(K_COMMIT, 16'd0, 14'd0));
        pending_reqs.push_back(mk(K_ALLOC, 16'd64, 14'd0));
        pending_reqs.push_back(mk(K_COMMIT, 16'd0, 14'd0));
        pending_reqs.push_back(mk(K_PAUSE, 16'd0, 14'd0));
        pending_reqs.push_back(mk(K_ALLOC, 16'd40, 14'd0));
        pending_reqs.push_back(mk(K_RESUME, 16'd0, 14'd0));
        pending_reqs.push_back(mk(K_RESUME, 16'd0, 14'd0));
        pending_reqs.push_back(mk(K_ALLOC, 16'd40, 14'd0));
        pending_reqs.push_back(mk(K_PAUSE, 16'd0, 14'd0));
        pending_reqs.push_back(mk(K_COMMIT, 16'd0, 14'd0));
        wait_drained();

        write_reg(CFG_AREA_BYTES, 15'd256);
        queue_commit_all();
        queue_traffic(200, 80);
        // long receiver hold while the sender keeps offering
        rx_hold <= 300;
        wait_drained();

        write_reg(CFG_AREA_BYTES, 15'h7fff);
        queue_commit_all();
        queue_traffic(200, 1100);
        repeat (200) @(posedge i_clk);
        // sender pauses until every expected result has come
        sender_hold = 1;
        while (i_valid || expected_resps.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sender_hold = 0;
        wait_drained();

        // area shrinks under live records
        write_reg(CFG_AREA_BYTES, 15'd1002);
        queue_commit_all();
        queue_traffic(150, 300);
        wait_drained();

        write_reg(CFG_RECORDING_EN, 15'd0);
        queue_traffic(30, 200);
        wait_drained();
        write_reg(CFG_RECORDING_EN, 15'd1);
        write_reg(CFG_MANAGER_EN, 15'd0);
        queue_traffic(30, 200);
        wait_drained();
        write_reg(CFG_MANAGER_EN, 15'd1);
        write_reg(CFG_AREA_BYTES, 15'd16384);
        no_idle = 1;
        queue_commit_all();
        queue_traffic(150, 1024);
        wait_drained();

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/lrra_pkg.sv
hw/rtl/log_ring_record_allocator.sv
hw/rtl/lrra_checker.sv
tb/tb_log_ring_record_allocator.sv
